// ----- rtl/core/ima_adpcm_block_decoder_assert.svh -----
// assertion macros shared by the ima adpcm block decoder rtl
// expects aclk and aresetn in the scope where a macro is used
`ifndef IMA_ADPCM_BLOCK_DECODER_ASSERT_SVH
`define IMA_ADPCM_BLOCK_DECODER_ASSERT_SVH

// property checked at every clock edge outside reset
`define IMAD_CHECK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition that must never be seen outside reset
`define IMAD_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ----- rtl/core/imad_pkg.sv -----
// shared types, constants and tables of the ima adpcm block decoder
// no dependencies
package imad_pkg;

    localparam int unsigned BLOCK_BYTES_W = 13;
    localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_RESET = 13'd1024;
    localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_MIN   = 13'd5;
    localparam logic [6:0] STEP_MAX_INDEX = 7'd88;

    typedef enum logic [1:0] {
        CMD_PRED,
        CMD_STEP,
        CMD_NIBS
    } imad_cmd_kind_t;

    // work item handed from the framing stage to the decode stage
    typedef struct packed {
        imad_cmd_kind_t kind;
        logic [15:0]    data;
    } imad_cmd_t;

    localparam logic [14:0] STEP_TABLE [0:88] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
        15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
        15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
        15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
        15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
        15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
        15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
        15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
        15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
        15'd27086, 15'd29794, 15'd32767
    };

    function automatic logic [14:0] step_size(input logic [6:0] idx);
        logic [14:0] s;
        if (idx > STEP_MAX_INDEX) begin
            s = STEP_TABLE[STEP_MAX_INDEX];
        end else begin
            s = STEP_TABLE[idx];
        end
        return s;
    endfunction

    // index change for the magnitude bits of a nibble
    function automatic logic signed [4:0] index_move(input logic [2:0] mag);
        logic signed [4:0] m;
        unique case (mag)
            3'd4:    m = 5'sd2;
            3'd5:    m = 5'sd4;
            3'd6:    m = 5'sd6;
            3'd7:    m = 5'sd8;
            default: m = -5'sd1;
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/core/imad_frame.sv -----
// block framing: byte position, preamble capture, input register
// depends on imad_pkg
module imad_frame import imad_pkg::*; #(
    parameter int unsigned MAX_BLOCK_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_word_start,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output imad_cmd_t   cmd
);

    // register is 13 bits wide, so a larger limit clamps to 8191
    localparam int unsigned MAX_LEN = (MAX_BLOCK_BYTES > 8191) ? 8191 : MAX_BLOCK_BYTES;
    localparam logic [BLOCK_BYTES_W-1:0] MAX_LEN_C = BLOCK_BYTES_W'(MAX_LEN);

    logic [BLOCK_BYTES_W-1:0] block_bytes_reg;
    logic [BLOCK_BYTES_W-1:0] pos_reg;
    logic [BLOCK_BYTES_W-1:0] pos_next;
    logic [7:0]               low_byte_reg;
    logic                     in_valid_reg;
    logic                     in_valid_next;
    imad_cmd_t                cmd_reg;
    imad_cmd_t                cmd_next;

    logic [BLOCK_BYTES_W-1:0] len;
    logic [BLOCK_BYTES_W-1:0] pos_eff;
    logic [BLOCK_BYTES_W:0]   pos_inc;
    logic                     accept;
    logic                     need_cmd;

    assign cfg_ready = 1'b1;
    assign s_ready   = !in_valid_reg || cmd_ready;
    assign accept    = s_valid && s_ready;
    assign cmd_valid = in_valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        priority if (block_bytes_reg < BLOCK_BYTES_MIN) begin
            len = BLOCK_BYTES_MIN;
        end else if (block_bytes_reg > MAX_LEN_C) begin
            len = MAX_LEN_C;
        end else begin
            len = block_bytes_reg;
        end
    end

    always_comb begin
        pos_eff  = s_word_start ? '0 : pos_reg;
        pos_inc  = {1'b0, pos_eff} + {{BLOCK_BYTES_W{1'b0}}, 1'b1};
        pos_next = (pos_inc >= {1'b0, len}) ? '0 : pos_inc[BLOCK_BYTES_W-1:0];

        need_cmd = 1'b1;
        cmd_next.data = {8'd0, s_data_byte};
        priority if (pos_eff == BLOCK_BYTES_W'(1)) begin
            cmd_next.kind = CMD_PRED;
            cmd_next.data = {s_data_byte, low_byte_reg};
        end else if (pos_eff == BLOCK_BYTES_W'(2)) begin
            cmd_next.kind = CMD_STEP;
        end else if (pos_eff >= BLOCK_BYTES_W'(4)) begin
            cmd_next.kind = CMD_NIBS;
        end else begin
            // predictor low byte and reserved byte give no work
            cmd_next.kind = CMD_NIBS;
            need_cmd      = 1'b0;
        end

        in_valid_next = (accept && need_cmd) || (in_valid_reg && !cmd_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_bytes_reg <= BLOCK_BYTES_RESET;
            pos_reg         <= '0;
            low_byte_reg    <= '0;
            in_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                block_bytes_reg <= cfg_data;
            end
            if (accept) begin
                pos_reg <= pos_next;
                if (pos_eff == '0) begin
                    low_byte_reg <= s_data_byte;
                end
            end
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && need_cmd) begin
            cmd_reg <= cmd_next;
        end
    end

`include "ima_adpcm_block_decoder_assert.svh"

    `IMAD_CHECK(a_word_start_pos, accept && s_word_start |=> pos_reg == BLOCK_BYTES_W'(1), "word start did not restart the block")
    `IMAD_CHECK(a_cfg_write, cfg_valid |=> block_bytes_reg == $past(cfg_data), "block length write lost")
    `IMAD_CHECK(a_cmd_hold, in_valid_reg && !cmd_ready |=> in_valid_reg && $stable(cmd_reg), "pending work item changed")

endmodule

// ----- rtl/core/imad_decode.sv -----
// decode stage: predictor and step index state, result register, one nibble per cycle while the result register is free
// depends on imad_pkg
module imad_decode import imad_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  imad_cmd_t   cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_sample,
    output logic        m_last_of_run
);

    logic               work_valid_reg;
    imad_cmd_t          work_reg;
    logic               phase_reg;
    logic signed [15:0] predictor_reg;
    logic [6:0]         step_index_reg;
    logic               out_valid_reg;
    logic [15:0]        out_sample_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               fire;
    logic               work_done;
    logic [3:0]         nib;
    logic [14:0]        step;
    logic [18:0]        prod;
    logic [15:0]        diff;
    logic signed [17:0] sum;
    logic signed [15:0] pred_sat;
    logic signed [7:0]  idx_sum;
    logic [6:0]         idx_next;
    logic [6:0]         preamble_idx;

    assign out_free  = !out_valid_reg || m_ready;
    assign fire      = work_valid_reg && out_free;
    assign work_done = fire && ((work_reg.kind != CMD_NIBS) || phase_reg);
    assign cmd_ready = !work_valid_reg || work_done;

    assign m_valid       = out_valid_reg;
    assign m_sample      = out_sample_reg;
    assign m_last_of_run = out_last_reg;

    always_comb begin
        nib  = phase_reg ? work_reg.data[7:4] : work_reg.data[3:0];
        step = step_size(step_index_reg);
        // single truncation of ((2*mag+1)*step)>>3
        prod = 19'({nib[2:0], 1'b1}) * 19'(step);
        diff = prod[18:3];
        if (nib[3]) begin
            sum = 18'(predictor_reg) - $signed({2'b00, diff});
        end else begin
            sum = 18'(predictor_reg) + $signed({2'b00, diff});
        end
        priority if (sum > 18'sd32767) begin
            pred_sat = 16'sh7FFF;
        end else if (sum < -18'sd32768) begin
            pred_sat = 16'sh8000;
        end else begin
            pred_sat = sum[15:0];
        end

        idx_sum = $signed({1'b0, step_index_reg}) + 8'(index_move(nib[2:0]));
        priority if (idx_sum < 8'sd0) begin
            idx_next = '0;
        end else if (idx_sum > $signed({1'b0, STEP_MAX_INDEX})) begin
            idx_next = STEP_MAX_INDEX;
        end else begin
            idx_next = idx_sum[6:0];
        end

        preamble_idx = (work_reg.data[7:0] > {1'b0, STEP_MAX_INDEX}) ?
                       STEP_MAX_INDEX : work_reg.data[6:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
            predictor_reg  <= '0;
            step_index_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd_ready) begin
                work_valid_reg <= cmd_valid;
                phase_reg      <= 1'b0;
            end else if (fire) begin
                // low nibble done, high nibble next
                phase_reg <= 1'b1;
            end

            if (fire) begin
                unique case (work_reg.kind)
                    CMD_PRED: begin
                        predictor_reg <= work_reg.data;
                        out_valid_reg <= 1'b1;
                    end
                    CMD_STEP: begin
                        step_index_reg <= preamble_idx;
                        out_valid_reg  <= 1'b0;
                    end
                    CMD_NIBS: begin
                        predictor_reg  <= pred_sat;
                        step_index_reg <= idx_next;
                        out_valid_reg  <= 1'b1;
                    end
                    default: begin
                        out_valid_reg <= 1'b0;
                    end
                endcase
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_ready && cmd_valid) begin
            work_reg <= cmd;
        end
        if (fire) begin
            if (work_reg.kind == CMD_PRED) begin
                out_sample_reg <= work_reg.data;
                out_last_reg   <= 1'b1;
            end else begin
                out_sample_reg <= pred_sat;
                out_last_reg   <= phase_reg;
            end
        end
    end

`include "ima_adpcm_block_decoder_assert.svh"

    `IMAD_NEVER(a_idx_range, step_index_reg > STEP_MAX_INDEX, "step index out of range")
    `IMAD_NEVER(a_phase_kind, work_valid_reg && phase_reg && work_reg.kind != CMD_NIBS, "high nibble phase on a preamble item")
    `IMAD_CHECK(a_low_then_high, fire && work_reg.kind == CMD_NIBS && !phase_reg |=> work_valid_reg && phase_reg, "high nibble lost after low nibble")
    `IMAD_CHECK(a_step_no_out, fire && work_reg.kind == CMD_STEP |=> !out_valid_reg, "step index byte produced a sample")

endmodule

// ----- rtl/core/ima_adpcm_block_decoder.sv -----
// top level of the ima adpcm block decoder
// depends on imad_pkg, imad_frame, imad_decode
//
// Decodes a byte stream of WAV-style IMA ADPCM blocks (4-byte preamble, then two 4-bit
// codes per byte, low nibble first) into 16-bit signed PCM. Bytes enter through s_*, samples
// leave through m_*; the user must write the block length through cfg_* only while the
// decoder is idle, which the block does not enforce (reset value 1024, values below 5 act
// as 5). A transfer on the input lands in an input register; the decode stage handles one
// nibble per cycle while its result register is free, since each nibble's step multiply and
// saturating add depend on the predictor left by the one before. A data byte gives two
// samples, the predictor high byte one and the step index byte none; the predictor low byte
// and the reserved byte give no work. The input register holds the next item while the
// single nibble unit works through the current one. The result register holds a sample
// until m_ready, and meanwhile the input side takes bytes only until its register fills.
module ima_adpcm_block_decoder import imad_pkg::*; #(
    parameter int unsigned MAX_BLOCK_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_word_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_sample,
    output logic        m_last_of_run
);

    logic        cmd_valid;
    logic        cmd_ready;
    imad_cmd_t   cmd;
    logic [15:0] sample_bits;

    imad_frame #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_frame (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_word_start (s_word_start),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    imad_decode u_decode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample      (sample_bits),
        .m_last_of_run (m_last_of_run)
    );

    assign m_sample = $signed(sample_bits);

endmodule
